// ----- src/edfq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// EDF request queue package
// Operation and status codes and the command word shared by the queue cells.
// ---------------------------------------------------------------------------
package edfq_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

endpackage

// ----- src/edf_request_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// EDF request queue
// Deadline-ordered request queue built as a chain of entry cells.
// ---------------------------------------------------------------------------
// The queue takes one command word in every clock cycle; busy never rises.
// Each cell compares its own deadline with the incoming one in parallel, so
// an insert, get or remove completes in the cycle after start. The
// result word appears in the cycle after the command with done high for that
// cycle only and must be captured then.
module edf_request_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int DEADLINE_BITS = 32,
	parameter int TAG_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       operation,
	input  logic [TAG_BITS-1:0]              request_tag,
	input  logic [DEADLINE_BITS-1:0]         deadline,
	output logic                             done,
	output logic                             head_valid,
	output logic [TAG_BITS-1:0]              head_tag,
	output logic [DEADLINE_BITS-1:0]         head_deadline,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
	output logic [1:0]                       status
);
	import edfq_pkg::*;

	localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

	logic [QUEUE_DEPTH-1:0]     valid;
	logic [QUEUE_DEPTH-1:0]     ge;
	logic [DEADLINE_BITS-1:0]   cell_deadline [QUEUE_DEPTH];
	logic [TAG_BITS-1:0]        cell_tag [QUEUE_DEPTH];
	logic [CountBits-1:0]       count_q;
	logic                       in_service_q;
	logic                       done_q;
	status_t                    status_q;
	status_t                    status_d;
	cmd_t                       cmd;
	logic                       full;
	logic                       empty;
	logic                       get_ok;

	assign full  = (count_q == CountBits'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd      = '0;
		get_ok   = 1'b0;
		status_d = ST_OK;
		if (start) begin
			case (operation)
				OP_INSERT: begin
					if (full) status_d = ST_FULL;
					else cmd.ins = 1'b1;
				end
				OP_GET: begin
					get_ok = !empty;
				end
				OP_REMOVE: begin
					if (empty) status_d = ST_EMPTY;
					else cmd.rem = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic                     p_ge;
			logic                     p_valid;
			logic [DEADLINE_BITS-1:0] p_deadline;
			logic [TAG_BITS-1:0]      p_tag;
			logic                     n_valid;
			logic [DEADLINE_BITS-1:0] n_deadline;
			logic [TAG_BITS-1:0]      n_tag;
			logic                     c_lock;
			if (i == 0) begin : g_first
				assign p_ge       = 1'b1;
				assign p_valid    = 1'b0;
				assign p_deadline = deadline;
				assign p_tag      = request_tag;
				assign c_lock     = in_service_q;
			end else begin : g_mid
				assign p_ge       = ge[i-1];
				assign p_valid    = valid[i-1];
				assign p_deadline = cell_deadline[i-1];
				assign p_tag      = cell_tag[i-1];
				assign c_lock     = 1'b0;
			end
			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign n_valid    = 1'b0;
				assign n_deadline = cell_deadline[i];
				assign n_tag      = cell_tag[i];
			end else begin : g_inner
				assign n_valid    = valid[i+1];
				assign n_deadline = cell_deadline[i+1];
				assign n_tag      = cell_tag[i+1];
			end
			edfq_cell #(
				.DEADLINE_BITS(DEADLINE_BITS),
				.TAG_BITS(TAG_BITS)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.cmd(cmd),
				.new_deadline(deadline),
				.new_tag(request_tag),
				.lock(c_lock),
				.prev_ge(p_ge),
				.prev_valid(p_valid),
				.prev_deadline(p_deadline),
				.prev_tag(p_tag),
				.next_valid(n_valid),
				.next_deadline(n_deadline),
				.next_tag(n_tag),
				.valid(valid[i]),
				.entry_deadline(cell_deadline[i]),
				.entry_tag(cell_tag[i]),
				.ge(ge[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			in_service_q <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
		end else begin
			done_q <= start;
			if (start) status_q <= status_d;
			if (cmd.ins) count_q <= count_q + 1'b1;
			else if (cmd.rem) count_q <= count_q - 1'b1;
			if (cmd.rem) in_service_q <= 1'b0;
			else if (get_ok) in_service_q <= 1'b1;
		end
	end

	assign busy          = 1'b0;
	assign done          = done_q;
	assign head_valid    = valid[0];
	assign head_tag      = valid[0] ? cell_tag[0] : '0;
	assign head_deadline = valid[0] ? cell_deadline[0] : '0;
	assign count         = count_q;
	assign status        = status_q;

`ifndef NO_ASSERTIONS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid) == 32'(count_q))
		else $error("entry count disagrees with valid cells");
	a_service_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_service_q |-> valid[0])
		else $error("head in service while queue is empty");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the queue");
	a_full_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		(start && full && operation == OP_INSERT) |=> $stable(valid) && status_q == ST_FULL)
		else $error("insert into a full queue changed the cells");
`endif

endmodule

// ----- src/edfq_cell.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// EDF queue cell
// Holds one queue entry and shifts, keeps or loads it on an insert or remove.
// ---------------------------------------------------------------------------
module edfq_cell #(
	parameter int DEADLINE_BITS = 32,
	parameter int TAG_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  edfq_pkg::cmd_t           cmd,
	input  logic [DEADLINE_BITS-1:0] new_deadline,
	input  logic [TAG_BITS-1:0]      new_tag,
	input  logic                     lock,
	input  logic                     prev_ge,
	input  logic                     prev_valid,
	input  logic [DEADLINE_BITS-1:0] prev_deadline,
	input  logic [TAG_BITS-1:0]      prev_tag,
	input  logic                     next_valid,
	input  logic [DEADLINE_BITS-1:0] next_deadline,
	input  logic [TAG_BITS-1:0]      next_tag,
	output logic                     valid,
	output logic [DEADLINE_BITS-1:0] entry_deadline,
	output logic [TAG_BITS-1:0]      entry_tag,
	output logic                     ge
);
	import edfq_pkg::*;

	logic                     valid_q;
	logic [DEADLINE_BITS-1:0] deadline_q;
	logic [TAG_BITS-1:0]      tag_q;

	// An entry stays ahead of a new word when it is locked or not later.
	assign ge = valid_q && (lock || (deadline_q <= new_deadline));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.rem) begin
			valid_q <= next_valid;
		end else if (cmd.ins && !ge) begin
			valid_q <= prev_ge ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rem) begin
			deadline_q <= next_deadline;
			tag_q      <= next_tag;
		end else if (cmd.ins && !ge) begin
			deadline_q <= prev_ge ? new_deadline : prev_deadline;
			tag_q      <= prev_ge ? new_tag : prev_tag;
		end
	end

	assign valid          = valid_q;
	assign entry_deadline = deadline_q;
	assign entry_tag      = tag_q;

endmodule
